// ===== src/rdqs_pkg.sv =====
package rdqs_pkg;

  // Working format: signed Q.16, magnitude saturates at 2^47-1.
  localparam int WW = 49;
  localparam int MW = 48;
  typedef logic signed [WW-1:0] w_t;
  localparam logic [MW-1:0] WMAX = 48'h7FFF_FFFF_FFFF;

  localparam int MAX_JOINTS_DEF = 32;
  localparam int JC_W = 6;
  localparam int IDX_W = 5;
  localparam int PIX_W = 16;
  localparam int Z_W = 24;
  localparam int L_W = 24;
  localparam int ROOT_W = 32;

  // Register map indexes.
  localparam logic [1:0] REG_JOINT_COUNT = 2'd0;
  localparam logic [1:0] REG_FIRST_IDX = 2'd1;
  localparam logic [1:0] REG_SECOND_IDX = 2'd2;
  localparam logic [1:0] REG_BONE_LENGTH = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic signed [Z_W-1:0] z;
  } joint_t;

  typedef struct packed {
    logic [PIX_W-1:0] fx;
    logic [PIX_W-1:0] fy;
    logic [PIX_W-1:0] cu;
    logic [PIX_W-1:0] cv;
  } cam_t;

  typedef enum logic [2:0] {
    OP_RATX, OP_RATY, OP_MUL, OP_ADD, OP_SUB, OP_CHK, OP_SQRT, OP_DIV
  } op_t;

  // Register file slots of the solver.
  localparam logic [3:0] RF_X = 4'd0;
  localparam logic [3:0] RF_Y = 4'd1;
  localparam logic [3:0] RF_PX = 4'd2;
  localparam logic [3:0] RF_TX = 4'd3;
  localparam logic [3:0] RF_PY = 4'd4;
  localparam logic [3:0] RF_TY = 4'd5;
  localparam logic [3:0] RF_ZN = 4'd6;
  localparam logic [3:0] RF_ZM = 4'd7;
  localparam logic [3:0] RF_L = 4'd8;
  localparam logic [3:0] RF_A = 4'd9;
  localparam logic [3:0] RF_B = 4'd10;
  localparam logic [3:0] RF_C = 4'd11;
  localparam logic [3:0] RF_T = 4'd12;
  localparam logic [3:0] RF_U = 4'd13;
  localparam int RF_LOAD_LAST = 8;

  typedef struct packed {
    op_t op;
    logic [3:0] dst;
    logic [3:0] a;
    logic [3:0] b;
  } instr_t;

  localparam int PROG_LEN = 37;
  localparam int PC_W = $clog2(PROG_LEN);

  // Solve program: ratios, projections, coefficients, discriminant, root.
  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0: i = '{OP_RATX, RF_X, RF_X, RF_X};
      6'd1: i = '{OP_RATY, RF_Y, RF_Y, RF_Y};
      6'd2: i = '{OP_RATX, RF_PX, RF_PX, RF_PX};
      6'd3: i = '{OP_RATX, RF_TX, RF_TX, RF_TX};
      6'd4: i = '{OP_RATY, RF_PY, RF_PY, RF_PY};
      6'd5: i = '{OP_RATY, RF_TY, RF_TY, RF_TY};
      6'd6: i = '{OP_MUL, RF_PX, RF_PX, RF_ZN};
      6'd7: i = '{OP_MUL, RF_TX, RF_TX, RF_ZM};
      6'd8: i = '{OP_SUB, RF_PX, RF_PX, RF_TX};
      6'd9: i = '{OP_MUL, RF_PY, RF_PY, RF_ZN};
      6'd10: i = '{OP_MUL, RF_TY, RF_TY, RF_ZM};
      6'd11: i = '{OP_SUB, RF_PY, RF_PY, RF_TY};
      6'd12: i = '{OP_SUB, RF_ZN, RF_ZN, RF_ZM};
      6'd13: i = '{OP_MUL, RF_A, RF_X, RF_X};
      6'd14: i = '{OP_MUL, RF_B, RF_Y, RF_Y};
      6'd15: i = '{OP_ADD, RF_A, RF_A, RF_B};
      6'd16: i = '{OP_MUL, RF_B, RF_X, RF_PX};
      6'd17: i = '{OP_MUL, RF_C, RF_Y, RF_PY};
      6'd18: i = '{OP_ADD, RF_B, RF_B, RF_C};
      6'd19: i = '{OP_ADD, RF_B, RF_B, RF_B};
      6'd20: i = '{OP_MUL, RF_C, RF_PX, RF_PX};
      6'd21: i = '{OP_MUL, RF_T, RF_PY, RF_PY};
      6'd22: i = '{OP_ADD, RF_C, RF_C, RF_T};
      6'd23: i = '{OP_MUL, RF_T, RF_ZN, RF_ZN};
      6'd24: i = '{OP_MUL, RF_U, RF_L, RF_L};
      6'd25: i = '{OP_SUB, RF_T, RF_T, RF_U};
      6'd26: i = '{OP_ADD, RF_C, RF_C, RF_T};
      6'd27: i = '{OP_MUL, RF_C, RF_A, RF_C};
      6'd28: i = '{OP_ADD, RF_C, RF_C, RF_C};
      6'd29: i = '{OP_ADD, RF_C, RF_C, RF_C};
      6'd30: i = '{OP_MUL, RF_T, RF_B, RF_B};
      6'd31: i = '{OP_SUB, RF_T, RF_T, RF_C};
      6'd32: i = '{OP_CHK, RF_T, RF_A, RF_T};
      6'd33: i = '{OP_SQRT, RF_T, RF_T, RF_T};
      6'd34: i = '{OP_SUB, RF_T, RF_T, RF_B};
      6'd35: i = '{OP_ADD, RF_U, RF_A, RF_A};
      6'd36: i = '{OP_DIV, RF_T, RF_T, RF_U};
      default: i = '{OP_ADD, RF_X, RF_X, RF_X};
    endcase
    return i;
  endfunction

  function automatic w_t wsat(input logic signed [WW:0] x);
    logic signed [WW:0] hi;
    logic signed [WW:0] lo;
    hi = $signed({2'b00, WMAX});
    lo = -hi;
    if (x > hi) return w_t'(hi);
    if (x < lo) return w_t'(lo);
    return w_t'(x);
  endfunction

  function automatic logic [MW-1:0] wmag(input w_t x);
    w_t n;
    n = -x;
    return x[WW-1] ? n[MW-1:0] : x[MW-1:0];
  endfunction

endpackage

// ===== src/rdqs_solver.sv =====
// Sequenced solver: a small register file and one bit-serial unit that
// multiplies, divides or takes a square root one bit (two for the root) a cycle.
module rdqs_solver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  rdqs_pkg::cam_t                   cam,
  input  rdqs_pkg::joint_t                 jn,
  input  rdqs_pkg::joint_t                 jm,
  input  logic [rdqs_pkg::L_W-1:0]         bone_length,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rdqs_pkg::ROOT_W-1:0] out_root,
  output logic                             out_none
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_FETCH = 6'b000100,
    S_EXEC  = 6'b001000,
    S_WB    = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam logic [6:0] MUL_END = 7'd49;
  localparam logic [6:0] DIV_END = 7'd65;
  localparam logic [6:0] SQRT_END = 7'd33;

  state_t state_r, state_nxt;
  logic [rdqs_pkg::PC_W-1:0] pc_r;
  logic [6:0] cnt_r;
  logic out_valid_r;
  rdqs_pkg::cam_t cam_r;
  rdqs_pkg::instr_t ins;

  rdqs_pkg::w_t rf_mem [16];
  rdqs_pkg::w_t rd_a_r, rd_b_r, wb_r, load_val;
  logic [rdqs_pkg::MW-1:0] mc_r;
  logic [2*rdqs_pkg::MW:0] mp_r;
  logic [63:0] dq_r;
  logic [rdqs_pkg::WW:0] rem_r;
  logic [rdqs_pkg::WW-1:0] dv_r;
  logic [31:0] sq_r;
  logic sgn_r;
  logic signed [rdqs_pkg::ROOT_W-1:0] root_r, res_root_r;
  logic none_r, res_none_r;

  logic [rdqs_pkg::MW:0] mul_hi;
  logic [rdqs_pkg::WW:0] div_trial, sq_rem, sq_trial;
  logic [79:0] mul_t;
  logic [rdqs_pkg::MW-1:0] mul_r;
  logic [rdqs_pkg::MW-1:0] mag_a;
  logic chk_fail, exec_done;

  assign ins = rdqs_pkg::prog(pc_r);
  assign mag_a = rdqs_pkg::wmag(rd_a_r);
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_root = root_r;
  assign out_none = none_r;

  // Operand values loaded into the register file before the program runs.
  always_comb begin
    case (cnt_r[3:0])
      rdqs_pkg::RF_X: load_val = rdqs_pkg::w_t'($signed({1'b0, jn.u}) - $signed({1'b0, jm.u}));
      rdqs_pkg::RF_Y: load_val = rdqs_pkg::w_t'($signed({1'b0, jn.v}) - $signed({1'b0, jm.v}));
      rdqs_pkg::RF_PX: load_val = rdqs_pkg::w_t'($signed({1'b0, jn.u}) - $signed({1'b0, cam_r.cu}));
      rdqs_pkg::RF_TX: load_val = rdqs_pkg::w_t'($signed({1'b0, jm.u}) - $signed({1'b0, cam_r.cu}));
      rdqs_pkg::RF_PY: load_val = rdqs_pkg::w_t'($signed({1'b0, jn.v}) - $signed({1'b0, cam_r.cv}));
      rdqs_pkg::RF_TY: load_val = rdqs_pkg::w_t'($signed({1'b0, jm.v}) - $signed({1'b0, cam_r.cv}));
      rdqs_pkg::RF_ZN: load_val = rdqs_pkg::w_t'(jn.z);
      rdqs_pkg::RF_ZM: load_val = rdqs_pkg::w_t'(jm.z);
      rdqs_pkg::RF_L: load_val = rdqs_pkg::w_t'({1'b0, bone_length});
      default: load_val = '0;
    endcase
  end

  // One step of each serial unit.
  always_comb begin
    mul_hi = mp_r[2*rdqs_pkg::MW:rdqs_pkg::MW] + {1'b0, mc_r};
    mul_t = mp_r[95:16];
    mul_r = (mul_t > {32'b0, rdqs_pkg::WMAX}) ? rdqs_pkg::WMAX : mul_t[rdqs_pkg::MW-1:0];
    div_trial = {rem_r[rdqs_pkg::WW-1:0], dq_r[63]};
    sq_rem = {rem_r[rdqs_pkg::WW-2:0], dq_r[63:62]};
    sq_trial = {16'b0, sq_r, 2'b01};
    // A zero leading coefficient or a discriminant that is zero or negative.
    chk_fail = (rd_a_r == '0) || (rd_b_r == '0) || rd_b_r[rdqs_pkg::WW-1];
    case (ins.op)
      rdqs_pkg::OP_MUL: exec_done = (cnt_r == MUL_END);
      rdqs_pkg::OP_RATX, rdqs_pkg::OP_RATY, rdqs_pkg::OP_DIV: exec_done = (cnt_r == DIV_END);
      rdqs_pkg::OP_SQRT: exec_done = (cnt_r == SQRT_END);
      default: exec_done = 1'b1;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_LOAD;
      S_LOAD: if (cnt_r == 7'(rdqs_pkg::RF_LOAD_LAST)) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC: begin
        if (ins.op == rdqs_pkg::OP_CHK) begin
          state_nxt = chk_fail ? S_DONE : S_FETCH;
        end else if (exec_done) begin
          state_nxt = (ins.op == rdqs_pkg::OP_DIV) ? S_DONE : S_WB;
        end
      end
      S_WB: state_nxt = S_FETCH;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and the result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        pc_r <= '0;
        cnt_r <= '0;
      end else if (state_r == S_LOAD) begin
        cnt_r <= (state_nxt == S_FETCH) ? 7'd0 : cnt_r + 7'd1;
      end else if (state_r == S_EXEC) begin
        cnt_r <= (state_nxt == S_EXEC) ? cnt_r + 7'd1 : 7'd0;
        if (ins.op == rdqs_pkg::OP_CHK) pc_r <= pc_r + 1'b1;
      end else if (state_r == S_WB) begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

  // Register file, read data registered.
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) rf_mem[cnt_r[3:0]] <= load_val;
    if (state_r == S_WB) rf_mem[ins.dst] <= wb_r;
    rd_a_r <= rf_mem[ins.a];
    rd_b_r <= rf_mem[ins.b];
  end

  // Datapath of the serial unit.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cam_r.fx <= (cam.fx == '0) ? 16'd1 : cam.fx;
      cam_r.fy <= (cam.fy == '0) ? 16'd1 : cam.fy;
      cam_r.cu <= cam.cu;
      cam_r.cv <= cam.cv;
    end
    if (state_r == S_DONE && state_nxt == S_IDLE) begin
      root_r <= res_root_r;
      none_r <= res_none_r;
    end
    if (state_r == S_EXEC) begin
      case (ins.op)
        rdqs_pkg::OP_ADD: wb_r <= rdqs_pkg::wsat({rd_a_r[rdqs_pkg::WW-1], rd_a_r}
                                  + {rd_b_r[rdqs_pkg::WW-1], rd_b_r});
        rdqs_pkg::OP_SUB: wb_r <= rdqs_pkg::wsat({rd_a_r[rdqs_pkg::WW-1], rd_a_r}
                                  - {rd_b_r[rdqs_pkg::WW-1], rd_b_r});
        rdqs_pkg::OP_CHK: begin
          res_root_r <= '0;
          res_none_r <= 1'b1;
        end
        rdqs_pkg::OP_MUL: begin
          if (cnt_r == 7'd0) begin
            mc_r <= mag_a;
            mp_r <= {49'b0, rdqs_pkg::wmag(rd_b_r)};
            sgn_r <= rd_a_r[rdqs_pkg::WW-1] ^ rd_b_r[rdqs_pkg::WW-1];
          end else if (cnt_r != MUL_END) begin
            if (mp_r[0]) begin
              mp_r <= {1'b0, mul_hi, mp_r[rdqs_pkg::MW-1:1]};
            end else begin
              mp_r <= {1'b0, mp_r[2*rdqs_pkg::MW:1]};
            end
          end else begin
            wb_r <= sgn_r ? -rdqs_pkg::w_t'({1'b0, mul_r}) : rdqs_pkg::w_t'({1'b0, mul_r});
          end
        end
        rdqs_pkg::OP_RATX, rdqs_pkg::OP_RATY, rdqs_pkg::OP_DIV: begin
          if (cnt_r == 7'd0) begin
            dq_r <= {mag_a, 16'b0};
            rem_r <= '0;
            sgn_r <= rd_a_r[rdqs_pkg::WW-1];
            case (ins.op)
              rdqs_pkg::OP_RATX: dv_r <= {33'b0, cam_r.fx};
              rdqs_pkg::OP_RATY: dv_r <= {33'b0, cam_r.fy};
              default: dv_r <= rd_b_r;
            endcase
          end else if (cnt_r != DIV_END) begin
            if (div_trial >= {1'b0, dv_r}) begin
              rem_r <= div_trial - {1'b0, dv_r};
              dq_r <= {dq_r[62:0], 1'b1};
            end else begin
              rem_r <= div_trial;
              dq_r <= {dq_r[62:0], 1'b0};
            end
          end else if (ins.op == rdqs_pkg::OP_DIV) begin
            // Saturate the quotient to the signed 32-bit result.
            if (sgn_r) begin
              res_root_r <= (dq_r > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(dq_r[31:0]);
            end else begin
              res_root_r <= (dq_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq_r[31:0]);
            end
            res_none_r <= 1'b0;
          end else begin
            wb_r <= sgn_r ? -rdqs_pkg::w_t'({16'b0, dq_r[32:0]})
                          : rdqs_pkg::w_t'({16'b0, dq_r[32:0]});
          end
        end
        rdqs_pkg::OP_SQRT: begin
          if (cnt_r == 7'd0) begin
            dq_r <= {mag_a, 16'b0};
            rem_r <= '0;
            sq_r <= '0;
          end else if (cnt_r != SQRT_END) begin
            dq_r <= {dq_r[61:0], 2'b00};
            if (sq_rem >= sq_trial) begin
              rem_r <= sq_rem - sq_trial;
              sq_r <= {sq_r[30:0], 1'b1};
            end else begin
              rem_r <= sq_rem;
              sq_r <= {sq_r[30:0], 1'b0};
            end
          end else begin
            wb_r <= rdqs_pkg::w_t'({17'b0, sq_r});
          end
        end
        default: wb_r <= '0;
      endcase
    end
  end

endmodule

// ===== src/root_depth_quadratic_solver_unit.sv =====
// The last joint beat of a sample starts the solve; its result beat goes valid
// once the single bit-serial multiply/divide/square-root unit has run the
// program (sooner when no root exists), plus any wait on out_stall.
// Throughput: one joint beat per cycle, and no beat is taken while a solve runs.
// Reset (rst_n low, synchronous) clears the joint counter, loads the register
// defaults and empties the result stage; saved joints are left as they are.
module root_depth_quadratic_solver_unit #(
  parameter int MAX_JOINTS = rdqs_pkg::MAX_JOINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rdqs_pkg::PIX_W-1:0]         in_joint_u,
  input  logic [rdqs_pkg::PIX_W-1:0]         in_joint_v,
  input  logic signed [rdqs_pkg::Z_W-1:0]    in_joint_depth,
  input  logic [rdqs_pkg::PIX_W-1:0]         in_focal_x,
  input  logic [rdqs_pkg::PIX_W-1:0]         in_focal_y,
  input  logic [rdqs_pkg::PIX_W-1:0]         in_center_u,
  input  logic [rdqs_pkg::PIX_W-1:0]         in_center_v,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rdqs_pkg::ROOT_W-1:0] out_root_depth,
  output logic                               out_no_solution
);

  localparam int CW = $clog2(MAX_JOINTS);

  logic [rdqs_pkg::JC_W-1:0] joint_count_r;
  logic [rdqs_pkg::IDX_W-1:0] first_idx_r, second_idx_r;
  logic [rdqs_pkg::L_W-1:0] bone_length_r;
  logic [CW-1:0] counter_r;
  rdqs_pkg::joint_t first_r, second_r, cur;
  rdqs_pkg::cam_t cam;
  logic [7:0] n_eff, cnt_ext;
  logic accept, last, busy;

  assign pready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign in_stall = busy;
  assign cur = '{in_joint_u, in_joint_v, in_joint_depth};
  assign cam = '{in_focal_x, in_focal_y, in_center_u, in_center_v};

  // Joint count clamped to one through MAX_JOINTS.
  always_comb begin
    n_eff = {2'b0, joint_count_r};
    if (n_eff == 8'd0) n_eff = 8'd1;
    if (n_eff > 8'(MAX_JOINTS)) n_eff = 8'(MAX_JOINTS);
    cnt_ext = 8'(counter_r);
    last = (cnt_ext + 8'd1 >= n_eff);
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      rdqs_pkg::REG_JOINT_COUNT: prdata = {26'b0, joint_count_r};
      rdqs_pkg::REG_FIRST_IDX: prdata = {27'b0, first_idx_r};
      rdqs_pkg::REG_SECOND_IDX: prdata = {27'b0, second_idx_r};
      rdqs_pkg::REG_BONE_LENGTH: prdata = {8'b0, bone_length_r};
      default: prdata = '0;
    endcase
  end

  // Register writes and the joint counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= 6'd21;
      first_idx_r <= 5'd0;
      second_idx_r <= 5'd1;
      bone_length_r <= 24'd65536;
      counter_r <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          rdqs_pkg::REG_JOINT_COUNT: joint_count_r <= pwdata[5:0];
          rdqs_pkg::REG_FIRST_IDX: first_idx_r <= pwdata[4:0];
          rdqs_pkg::REG_SECOND_IDX: second_idx_r <= pwdata[4:0];
          rdqs_pkg::REG_BONE_LENGTH: bone_length_r <= pwdata[23:0];
          default: bone_length_r <= bone_length_r;
        endcase
      end
      if (accept) counter_r <= last ? '0 : counter_r + 1'b1;
    end
  end

  // Keep the two joints of the bone.
  always_ff @(posedge clk) begin
    if (accept && cnt_ext == {3'b0, first_idx_r}) first_r <= cur;
    if (accept && cnt_ext == {3'b0, second_idx_r}) second_r <= cur;
  end

  rdqs_solver u_solver (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept && last),
    .cam        (cam),
    .jn         (first_r),
    .jm         (second_r),
    .bone_length(bone_length_r),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_root   (out_root_depth),
    .out_none   (out_no_solution)
  );

endmodule

// ===== tb/tb_root_depth_quadratic_solver_unit.sv =====
module tb_root_depth_quadratic_solver_unit;

  localparam longint WSAT_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 4000;
  localparam int SETTLE = 20;

  // One joint beat as it crosses the input channel.
  typedef struct {
    logic [rdqs_pkg::PIX_W-1:0] u;
    logic [rdqs_pkg::PIX_W-1:0] v;
    logic signed [rdqs_pkg::Z_W-1:0] z;
    logic [rdqs_pkg::PIX_W-1:0] fx;
    logic [rdqs_pkg::PIX_W-1:0] fy;
    logic [rdqs_pkg::PIX_W-1:0] cu;
    logic [rdqs_pkg::PIX_W-1:0] cv;
  } joint_beat_t;

  // Root depth predictor and the queue of roots it still expects.
  class root_depth_scoreboard;
    bit [rdqs_pkg::JC_W-1:0] joint_count;
    bit [rdqs_pkg::IDX_W-1:0] first_idx;
    bit [rdqs_pkg::IDX_W-1:0] second_idx;
    bit [rdqs_pkg::L_W-1:0] bone_len;
    int unsigned joint_pos;
    longint n_u, n_v, n_z, m_u, m_v, m_z;
    bit [rdqs_pkg::ROOT_W-1:0] root_q[$];
    bit none_q[$];
    int errors;

    function new();
      joint_count = 21;
      first_idx = 0;
      second_idx = 1;
      bone_len = 24'h010000;
      joint_pos = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
        rdqs_pkg::REG_JOINT_COUNT: joint_count = val[rdqs_pkg::JC_W-1:0];
        rdqs_pkg::REG_FIRST_IDX: first_idx = val[rdqs_pkg::IDX_W-1:0];
        rdqs_pkg::REG_SECOND_IDX: second_idx = val[rdqs_pkg::IDX_W-1:0];
        rdqs_pkg::REG_BONE_LENGTH: bone_len = val[rdqs_pkg::L_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(input longint x);
      if (x > WSAT_MAX) return WSAT_MAX;
      if (x < -WSAT_MAX) return -WSAT_MAX;
      return x;
    endfunction

    function bit [63:0] mag(input longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // Q.16 product truncated toward zero, then clipped.
    function longint qmul(input longint a, input longint b);
      bit [63:0] ma, mb, ah, al, bh, bl, hh, r;
      ma = mag(a);
      mb = mag(b);
      ah = ma >> 24;
      al = ma & 64'hFF_FFFF;
      bh = mb >> 24;
      bl = mb & 64'hFF_FFFF;
      hh = ah * bh;
      if (hh >= 64'd32768) begin
        r = WSAT_MAX;
      end else begin
        r = (hh << 32) + ((ah * bl + al * bh) << 8) + ((al * bl) >> 16);
        if (r > WSAT_MAX) r = WSAT_MAX;
      end
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function bit [63:0] int_sqrt(input bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Pixel offset over focal length in Q.16; a zero focal counts as one LSB.
    function longint pix_ratio(input longint diff, input logic [rdqs_pkg::PIX_W-1:0] f);
      longint fd;
      fd = (f == 0) ? 1 : longint'({48'd0, f});
      return (diff * 65536) / fd;
    endfunction

    function void solve_bone(input joint_beat_t cam);
      longint rdx, rdy, rnx, rmx, rny, rmy, px, py, dz, len, qa, qb, qc, ac, disc, num, den;
      bit [63:0] s, q;
      bit [rdqs_pkg::ROOT_W-1:0] root;
      rdx = pix_ratio(n_u - m_u, cam.fx);
      rdy = pix_ratio(n_v - m_v, cam.fy);
      rnx = pix_ratio(n_u - longint'({48'd0, cam.cu}), cam.fx);
      rmx = pix_ratio(m_u - longint'({48'd0, cam.cu}), cam.fx);
      rny = pix_ratio(n_v - longint'({48'd0, cam.cv}), cam.fy);
      rmy = pix_ratio(m_v - longint'({48'd0, cam.cv}), cam.fy);
      px = clip(qmul(rnx, n_z) - qmul(rmx, m_z));
      py = clip(qmul(rny, n_z) - qmul(rmy, m_z));
      dz = n_z - m_z;
      len = longint'({40'd0, bone_len});
      qa = clip(qmul(rdx, rdx) + qmul(rdy, rdy));
      qb = clip(qmul(rdx, px) + qmul(rdy, py));
      qb = clip(qb + qb);
      qc = clip(clip(qmul(px, px) + qmul(py, py)) + clip(qmul(dz, dz) - qmul(len, len)));
      ac = qmul(qa, qc);
      ac = clip(ac + ac);
      ac = clip(ac + ac);
      disc = clip(qmul(qb, qb) - ac);
      // No real root, or a degenerate bone: zero and the flag.
      if (qa == 0 || disc <= 0) begin
        root_q.push_back('0);
        none_q.push_back(1'b1);
        return;
      end
      s = int_sqrt(64'(disc) << 16);
      num = clip(longint'(s) - qb);
      den = clip(qa + qa);
      q = (mag(num) << 16) / 64'(den);
      if (num < 0) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        root = rdqs_pkg::ROOT_W'(-longint'(q));
      end else begin
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        root = rdqs_pkg::ROOT_W'(q);
      end
      root_q.push_back(root);
      none_q.push_back(1'b0);
    endfunction

    function void note_joint(input joint_beat_t j);
      int unsigned cnt;
      cnt = joint_count;
      if (cnt < 1) cnt = 1;
      if (cnt > rdqs_pkg::MAX_JOINTS_DEF) cnt = rdqs_pkg::MAX_JOINTS_DEF;
      if (joint_pos == first_idx) begin
        n_u = j.u;
        n_v = j.v;
        n_z = longint'(j.z);
      end
      if (joint_pos == second_idx) begin
        m_u = j.u;
        m_v = j.v;
        m_z = longint'(j.z);
      end
      if (joint_pos + 1 < cnt) begin
        joint_pos++;
      end else begin
        joint_pos = 0;
        solve_bone(j);
      end
    endfunction

    task check_result(input logic [rdqs_pkg::ROOT_W-1:0] root, input logic none);
      bit [rdqs_pkg::ROOT_W-1:0] er;
      bit en;
      if (root_q.size() == 0) begin
        report($sformatf("unexpected result root=%h no_solution=%b", root, none));
      end else begin
        er = root_q.pop_front();
        en = none_q.pop_front();
        if (root !== er) report($sformatf("root_depth %h, expected %h", root, er));
        if (none !== en) report($sformatf("no_solution %b, expected %b", none, en));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [rdqs_pkg::PIX_W-1:0] in_joint_u, in_joint_v, in_focal_x, in_focal_y;
  logic [rdqs_pkg::PIX_W-1:0] in_center_u, in_center_v;
  logic signed [rdqs_pkg::Z_W-1:0] in_joint_depth;
  logic out_valid, out_stall;
  logic signed [rdqs_pkg::ROOT_W-1:0] out_root_depth;
  logic out_no_solution;

  root_depth_quadratic_solver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_joint_u(in_joint_u), .in_joint_v(in_joint_v), .in_joint_depth(in_joint_depth),
    .in_focal_x(in_focal_x), .in_focal_y(in_focal_y),
    .in_center_u(in_center_u), .in_center_v(in_center_v),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_root_depth(out_root_depth), .out_no_solution(out_no_solution)
  );

  root_depth_scoreboard sb;
  bit calm;
  bit hold_req;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Beat monitors on both channels.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_joint('{in_joint_u, in_joint_v, in_joint_depth, in_focal_x, in_focal_y,
                      in_center_u, in_center_v});
    end
    if (rst_n && out_valid && !out_stall) sb.check_result(out_root_depth, out_no_solution);
  end

  // Watchdog on cycles in which no beat moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL root_depth_quadratic_solver_unit");
        $finish;
      end
    end
  end

  // Result side: random stall runs, plus one long hold on request.
  initial begin
    int hold, run;
    bit hold_done;
    hold = 0;
    run = 0;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (run > 0) begin
        run--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
      end
    end
  end

  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_joint(input joint_beat_t j);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_u <= j.u;
    in_joint_v <= j.v;
    in_joint_depth <= j.z;
    in_focal_x <= j.fx;
    in_focal_y <= j.fy;
    in_center_u <= j.cu;
    in_center_v <= j.cv;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.root_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_bone(input int cnt, input int n, input int m, input int len);
    write_reg(rdqs_pkg::REG_JOINT_COUNT, cnt);
    write_reg(rdqs_pkg::REG_FIRST_IDX, n);
    write_reg(rdqs_pkg::REG_SECOND_IDX, m);
    write_reg(rdqs_pkg::REG_BONE_LENGTH, len);
  endtask

  function automatic joint_beat_t noise_joint();
    joint_beat_t j;
    j.u = 16'($urandom);
    j.v = 16'($urandom);
    j.z = rdqs_pkg::Z_W'($urandom);
    j.fx = 16'($urandom);
    j.fy = 16'($urandom);
    j.cu = 16'($urandom);
    j.cv = 16'($urandom);
    return j;
  endfunction

  // A plausible camera with a joint scattered near the image center.
  function automatic joint_beat_t camera_joint(input joint_beat_t cam);
    joint_beat_t j;
    int pu, pv;
    j = cam;
    pu = int'(cam.cu) + $urandom_range(0, 9600) - 4800;
    pv = int'(cam.cv) + $urandom_range(0, 9600) - 4800;
    j.u = (pu < 0) ? 16'd0 : (pu > 65535) ? 16'hFFFF : pu[15:0];
    j.v = (pv < 0) ? 16'd0 : (pv > 65535) ? 16'hFFFF : pv[15:0];
    j.z = rdqs_pkg::Z_W'($urandom_range(0, 65536) - 32768);
    return j;
  endfunction

  function automatic joint_beat_t new_camera();
    joint_beat_t c;
    c = noise_joint();
    c.fx = 16'($urandom_range(3200, 32000));
    c.fy = 16'($urandom_range(3200, 32000));
    c.cu = 16'($urandom_range(1600, 9600));
    c.cv = 16'($urandom_range(1600, 9600));
    return c;
  endfunction

  task automatic send_sample(input int beats);
    joint_beat_t cam;
    cam = new_camera();
    repeat (beats) send_joint(camera_joint(cam));
  endtask

  initial begin
    joint_beat_t j;
    int cnt, eff, phase, sent;
    sb = new();
    calm = 0;
    hold_req = 0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_joint_u <= '0;
    in_joint_v <= '0;
    in_joint_depth <= '0;
    in_focal_x <= '0;
    in_focal_y <= '0;
    in_center_u <= '0;
    in_center_v <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: two-joint samples, field extremes and the odd cases.
    set_bone(2, 0, 1, 32'h0001_0000);
    send_sample(2);
    j = '{16'hFFFF, 16'h0000, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
    send_joint(j);
    j = '{16'h0000, 16'hFFFF, -24'sh800000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
    send_joint(j);
    // Zero focal lengths, and the principal point at its far corner.
    j = '{16'h1234, 16'h0800, 24'sh004000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
    send_joint(j);
    j.u = 16'h4321;
    send_joint(j);
    j = '{16'h0001, 16'hFFFE, 24'sh000100, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000};
    send_joint(j);
    send_joint(j);
    // Both indices on the same joint give a zero leading coefficient.
    write_reg(rdqs_pkg::REG_SECOND_IDX, 0);
    send_sample(2);
    // A zero count acts as one: every beat ends a sample.
    write_reg(rdqs_pkg::REG_JOINT_COUNT, 0);
    send_sample(2);
    write_reg(rdqs_pkg::REG_JOINT_COUNT, 1);
    send_sample(1);
    // Second index beyond the count keeps the old saved joint.
    set_bone(3, 1, 5, 32'h0000_8000);
    send_sample(3);
    // Count lowered in the middle of a sample.
    write_reg(rdqs_pkg::REG_JOINT_COUNT, 5);
    send_sample(3);
    write_reg(rdqs_pkg::REG_JOINT_COUNT, 2);
    send_sample(1);
    write_reg(rdqs_pkg::REG_BONE_LENGTH, 0);
    send_sample(2);
    write_reg(rdqs_pkg::REG_BONE_LENGTH, 32'h00FF_FFFF);
    send_sample(2);

    // Random phases: mostly whole samples, some noise beats.
    sent = 0;
    phase = 0;
    while (sent < 400) begin
      case ($urandom_range(0, 9))
        0: cnt = 63;
        1: cnt = 32;
        2: cnt = $urandom_range(0, 1);
        3: cnt = $urandom_range(7, 31);
        default: cnt = $urandom_range(2, 6);
      endcase
      eff = (cnt < 1) ? 1 : (cnt > 32) ? 32 : cnt;
      calm = ($urandom_range(0, 4) == 0);
      set_bone(cnt,
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, eff - 1),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, eff - 1),
               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(3000, 90000));
      if (phase == 2) hold_req = 1;
      repeat ((eff > 8) ? 2 : 6) begin
        if ($urandom_range(0, 5) == 0) begin
          send_joint(noise_joint());
          sent++;
        end else begin
          send_sample(eff);
          sent += eff;
        end
      end
      phase++;
    end
    in_valid <= 1'b0;

    while (sb.root_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS root_depth_quadratic_solver_unit");
    end else begin
      $display("FAIL root_depth_quadratic_solver_unit");
    end
    $finish;
  end

endmodule

// ===== root_depth_quadratic_solver_unit.f =====
src/rdqs_pkg.sv
src/rdqs_solver.sv
src/root_depth_quadratic_solver_unit.sv
tb/tb_root_depth_quadratic_solver_unit.sv
